>>> src/qkb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkb_pkg: shared types and constants
// Payload structs, register indexes and widths for the knob and button reader.
// ----------------------------------------------------------------------------
package qkb_pkg;

	// number of debounced pins: A, B, trigger, preset A..C
	localparam int PIN_N      = 6;
	// number of buttons reported
	localparam int BUTTON_N   = 4;
	// position register width (output fields are fixed at 32 bits)
	localparam int POS_W      = 32;
	// hold counter width per pin
	localparam int HOLD_W     = 16;
	// width of a hold count register and of the config data bus
	localparam int CFG_W      = 16;
	localparam int MASK_W     = 4;
	localparam int CFG_IDX_W  = 3;

	// level bit order inside the stable level vector
	localparam int LVL_A       = 0;
	localparam int LVL_B       = 1;
	localparam int LVL_BUTTON0 = 2;

	// register reset values
	localparam logic [CFG_W-1:0]  BUTTON_HOLD_RST  = CFG_W'(10);
	localparam logic [CFG_W-1:0]  ENCODER_HOLD_RST = CFG_W'(1);
	localparam logic [MASK_W-1:0] MASK_RST         = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIGGER_HOLD  = 3'd0,
		REG_PRESET_A_HOLD = 3'd1,
		REG_PRESET_B_HOLD = 3'd2,
		REG_PRESET_C_HOLD = 3'd3,
		REG_ENCODER_HOLD  = 3'd4,
		REG_CLOSED_MASK   = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic kind;
		logic raw_a;
		logic raw_b;
		logic raw_trigger;
		logic raw_preset_a;
		logic raw_preset_b;
		logic raw_preset_c;
	} sample_t;

	typedef struct packed {
		logic              trigger_on;
		logic              preset_a_on;
		logic              preset_b_on;
		logic              preset_c_on;
		logic              trigger_toggled;
		logic              preset_a_toggled;
		logic              preset_b_toggled;
		logic              preset_c_toggled;
		logic signed [31:0] position_delta;
		logic signed [31:0] position;
	} report_t;

	// sample kind: report after sampling
	localparam logic KIND_REPORT = 1'b1;

endpackage

>>> src/qkb_debounce_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkb_debounce_cell: one pin debouncer
// Holds the previous raw level, a saturating hold counter and the stable
// level of one pin; inserts its new stable level into the level vector that
// ripples along the row of cells.
// ----------------------------------------------------------------------------
module qkb_debounce_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         raw,
	input  logic [qkb_pkg::CFG_W-1:0]    hold,
	input  logic [qkb_pkg::PIN_N-1:0]    levels_in,
	output logic [qkb_pkg::PIN_N-1:0]    levels_out
);

	localparam logic [qkb_pkg::HOLD_W-1:0] CntMax = '1;

	logic                        prev_q;
	logic                        stable_q;
	logic [qkb_pkg::HOLD_W-1:0]  cnt_q;
	logic [qkb_pkg::HOLD_W-1:0]  cnt_d;
	logic                        stable_d;

	// counter restarts on a level change, else counts up and saturates
	always_comb begin
		if (raw != prev_q) begin
			cnt_d = '0;
		end else if (cnt_q != CntMax) begin
			cnt_d = cnt_q + 1'b1;
		end else begin
			cnt_d = cnt_q;
		end
		stable_d = (32'(cnt_d) >= 32'(hold)) ? raw : stable_q;
	end

	// shift own level in from the top; after the last cell bit i is cell i
	assign levels_out = {stable_d, levels_in[qkb_pkg::PIN_N-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b0;
			stable_q <= 1'b0;
			cnt_q    <= '0;
		end else if (en) begin
			prev_q   <= raw;
			stable_q <= stable_d;
			cnt_q    <= cnt_d;
		end
	end

endmodule

>>> src/qkb_quad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkb_quad: quadrature phase tracker
// Seven-phase sequence on the debounced A and B levels; a completed
// clockwise sequence counts up, an anticlockwise one counts down.
// ----------------------------------------------------------------------------
module qkb_quad (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      enc_a,
	input  logic                      enc_b,
	output logic [qkb_pkg::POS_W-1:0] pos_next
);

	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_CW1  = 7'b0000010,
		PH_CW2  = 7'b0000100,
		PH_CW3  = 7'b0001000,
		PH_CCW1 = 7'b0010000,
		PH_CCW2 = 7'b0100000,
		PH_CCW3 = 7'b1000000
	} phase_t;

	phase_t                     phase_q;
	phase_t                     phase_d;
	logic [qkb_pkg::POS_W-1:0]  pos_q;

	// next phase and position for this tick
	always_comb begin
		phase_d  = phase_q;
		pos_next = pos_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (!enc_a) begin
					phase_d = PH_CW1;
				end else if (!enc_b) begin
					phase_d = PH_CCW1;
				end
			end
			PH_CW1: begin
				if (!enc_b) phase_d = PH_CW2;
			end
			PH_CW2: begin
				if (enc_a) phase_d = PH_CW3;
			end
			PH_CW3: begin
				if (enc_a && enc_b) begin
					phase_d  = PH_IDLE;
					pos_next = pos_q + 1'b1;
				end
			end
			PH_CCW1: begin
				if (!enc_a) phase_d = PH_CCW2;
			end
			PH_CCW2: begin
				if (enc_b) phase_d = PH_CCW3;
			end
			PH_CCW3: begin
				if (enc_a && enc_b) begin
					phase_d  = PH_IDLE;
					pos_next = pos_q - 1'b1;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			pos_q   <= pos_next;
		end
	end

	// position only moves when a sequence completes
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pos_q) |-> $past(phase_q == PH_CW3 || phase_q == PH_CCW3))
		else $error("position changed outside a final phase");

	// a finished sequence always returns to idle
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pos_q) |-> phase_q == PH_IDLE)
		else $error("phase not idle after a count");

	// clockwise completion counts up by exactly one
	a_cw_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(en && phase_q == PH_CW3 && enc_a && enc_b) |=> pos_q == $past(pos_q) + 1'b1)
		else $error("clockwise step not counted");

endmodule

>>> src/quadrature_knob_and_button_reader.sv
`timescale 1ns / 1ps
// Output: a transferred report sample is loaded into the output register when that register is
//   empty or its report transfers at the same edge; else it waits in the skid entry.
// Throughput: one sample per cycle; sample_ready drops only while a second report waits in
//   the skid entry behind a stalled output register, and rises after the next report transfer.
// Reset: arst_n clears all debounce cells, phase, position, report history and output
//   valids; hold registers return to 10 (buttons) and 1 (encoder), closed-level mask to 0.
// ----------------------------------------------------------------------------
// quadrature_knob_and_button_reader: top level
// Row of six debounce cells, quadrature tracker, report logic and output
// register with skid stage.
// ----------------------------------------------------------------------------
module quadrature_knob_and_button_reader (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [qkb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qkb_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  qkb_pkg::sample_t              sample,
	output logic                          report_valid,
	input  logic                          report_ready,
	output qkb_pkg::report_t              report
);

	// configuration registers
	logic [qkb_pkg::BUTTON_N-1:0][qkb_pkg::CFG_W-1:0] button_hold_q;
	logic [qkb_pkg::CFG_W-1:0]                        enc_hold_q;
	logic [qkb_pkg::MASK_W-1:0]                       mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_hold_q <= {qkb_pkg::BUTTON_N{qkb_pkg::BUTTON_HOLD_RST}};
			enc_hold_q    <= qkb_pkg::ENCODER_HOLD_RST;
			mask_q        <= qkb_pkg::MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qkb_pkg::REG_TRIGGER_HOLD:  button_hold_q[0] <= cfg_data;
				qkb_pkg::REG_PRESET_A_HOLD: button_hold_q[1] <= cfg_data;
				qkb_pkg::REG_PRESET_B_HOLD: button_hold_q[2] <= cfg_data;
				qkb_pkg::REG_PRESET_C_HOLD: button_hold_q[3] <= cfg_data;
				qkb_pkg::REG_ENCODER_HOLD:  enc_hold_q       <= cfg_data;
				qkb_pkg::REG_CLOSED_MASK:   mask_q <= cfg_data[qkb_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// input transfer
	logic accept;
	logic skid_valid_q;

	assign sample_ready = !skid_valid_q;
	assign accept       = sample_valid && sample_ready;

	// debounce row
	logic [qkb_pkg::PIN_N-1:0]                    raw;
	logic [qkb_pkg::PIN_N-1:0][qkb_pkg::CFG_W-1:0] pin_hold;
	logic [qkb_pkg::PIN_N:0][qkb_pkg::PIN_N-1:0]  chain;
	logic [qkb_pkg::PIN_N-1:0]                    stable;

	assign raw = {sample.raw_preset_c, sample.raw_preset_b, sample.raw_preset_a,
		sample.raw_trigger, sample.raw_b, sample.raw_a};
	assign pin_hold = {button_hold_q, enc_hold_q, enc_hold_q};
	assign chain[0] = '0;
	assign stable   = chain[qkb_pkg::PIN_N];

	for (genvar i = 0; i < qkb_pkg::PIN_N; i++) begin : g_cell
		qkb_debounce_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (accept),
			.raw        (raw[i]),
			.hold       (pin_hold[i]),
			.levels_in  (chain[i]),
			.levels_out (chain[i+1])
		);
	end

	// quadrature tracking
	logic [qkb_pkg::POS_W-1:0] pos_next;

	qkb_quad u_quad (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (accept),
		.enc_a    (stable[qkb_pkg::LVL_A]),
		.enc_b    (stable[qkb_pkg::LVL_B]),
		.pos_next (pos_next)
	);

	// report build
	logic [qkb_pkg::BUTTON_N-1:0] on;
	logic [qkb_pkg::BUTTON_N-1:0] toggled;
	logic [qkb_pkg::BUTTON_N-1:0] reported_q;
	logic [qkb_pkg::POS_W-1:0]    last_pos_q;
	logic [qkb_pkg::POS_W-1:0]    delta;
	logic                         make_report;
	qkb_pkg::report_t             new_report;

	assign make_report = accept && (sample.kind == qkb_pkg::KIND_REPORT);
	assign on      = ~(stable[qkb_pkg::LVL_BUTTON0 +: qkb_pkg::BUTTON_N] ^ mask_q);
	assign toggled = on ^ reported_q;
	assign delta   = pos_next - last_pos_q;

	always_comb begin
		new_report.trigger_on       = on[0];
		new_report.preset_a_on      = on[1];
		new_report.preset_b_on      = on[2];
		new_report.preset_c_on      = on[3];
		new_report.trigger_toggled  = toggled[0];
		new_report.preset_a_toggled = toggled[1];
		new_report.preset_b_toggled = toggled[2];
		new_report.preset_c_toggled = toggled[3];
		new_report.position_delta   = 32'($signed(delta));
		new_report.position         = 32'($signed(pos_next));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q <= '0;
			last_pos_q <= '0;
		end else if (make_report) begin
			reported_q <= on;
			last_pos_q <= pos_next;
		end
	end

	// output register plus skid entry
	logic             out_valid_q;
	logic             out_fire;
	qkb_pkg::report_t out_q;
	qkb_pkg::report_t skid_q;

	assign out_fire     = out_valid_q && report_ready;
	assign report_valid = out_valid_q;
	assign report       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (make_report) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (make_report) begin
			if (!out_valid_q || out_fire) begin
				out_q <= new_report;
			end else begin
				skid_q <= new_report;
			end
		end
	end

	// skid entry is only used behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// a waiting skid entry is kept until the output moves
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !report_ready) |=> (skid_valid_q && $stable(skid_q)))
		else $error("skid entry lost while output stalled");

	// a report into an empty output shows up on the next cycle
	a_report_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(make_report && !out_valid_q) |=> (out_valid_q && out_q == $past(new_report)))
		else $error("report not loaded into output register");

endmodule

>>> test/quadrature_knob_and_button_reader_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_knob_and_button_reader_test: self-checking testbench
// Drives sample ticks through the valid/ready port and tracks debounce, the
// quadrature phase walk and the report history in a local copy of the reader.
// Every report transfer is compared field by field with the oldest one due.
// The run is a short scripted part, then random knob turns, broken turns,
// pin noise and button presses under three handshake pacing phases.
// ----------------------------------------------------------------------------
module quadrature_knob_and_button_reader_test;
	import qkb_pkg::*;

	// cycles with no transfer on either channel before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_TICKS_PER_PHASE = 570;

	// register indexes the block does not decode
	localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

	// quadrature phases
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_CW_A_LOW  = 3'd1;
	localparam logic [2:0] PH_CW_B_LOW  = 3'd2;
	localparam logic [2:0] PH_CW_A_HIGH = 3'd3;
	localparam logic [2:0] PH_CC_B_LOW  = 3'd4;
	localparam logic [2:0] PH_CC_A_LOW  = 3'd5;
	localparam logic [2:0] PH_CC_B_HIGH = 3'd6;

	typedef struct {
		sample_t pins;
		bit      zero_holds;
		bit      typed;
		report_t want;
	} tick_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             sample_valid;
	logic             sample_ready;
	sample_t          sample;
	logic             report_valid;
	logic             report_ready;
	report_t          report;

	// local copy of the reader: configuration and state
	logic [HOLD_W-1:0] hold_ticks [PIN_N];
	logic [MASK_W-1:0] closed_mask;
	logic [2:0]        knob_phase;
	logic [31:0]       steps;
	logic [31:0]       steps_at_report;
	logic [3:0]        flags_reported;
	logic [5:0]        stable;
	logic [5:0]        raw_prev;
	logic [HOLD_W-1:0] hold_cnt [PIN_N];

	report_t   reports_due [$];
	logic [1:0] knob_levels [$];
	logic [3:0] button_raw;
	tick_row_t script [0:17];

	// payload companions: a typed expectation travels with the sample
	bit      cur_typed;
	report_t cur_want;

	int send_idle_pct;
	int take_idle_pct;
	int mismatches;
	int samples_taken;
	int reports_checked;

	quadrature_knob_and_button_reader dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.report       (report)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one tick of the reader: debounce, phase step, optional report
	task automatic apply_tick(input sample_t s, output report_t r);
		logic [5:0] raw;
		logic [3:0] on;
		logic a, b;
		raw = {s.raw_preset_c, s.raw_preset_b, s.raw_preset_a, s.raw_trigger, s.raw_b, s.raw_a};
		for (int i = 0; i < PIN_N; i++) begin
			if (raw[i] != raw_prev[i]) begin
				raw_prev[i] = raw[i];
				hold_cnt[i] = '0;
			end else if (hold_cnt[i] != '1) begin
				hold_cnt[i] = hold_cnt[i] + 1'b1;
			end
			if (hold_cnt[i] >= hold_ticks[i])
				stable[i] = raw[i];
		end
		a = stable[LVL_A];
		b = stable[LVL_B];
		case (knob_phase)
			PH_IDLE: begin
				if (!a) knob_phase = PH_CW_A_LOW;
				else if (!b) knob_phase = PH_CC_B_LOW;
			end
			PH_CW_A_LOW: if (!b) knob_phase = PH_CW_B_LOW;
			PH_CW_B_LOW: if (a) knob_phase = PH_CW_A_HIGH;
			PH_CW_A_HIGH: begin
				if (a && b) begin
					knob_phase = PH_IDLE;
					steps = steps + 1;
				end
			end
			PH_CC_B_LOW: if (!a) knob_phase = PH_CC_A_LOW;
			PH_CC_A_LOW: if (b) knob_phase = PH_CC_B_HIGH;
			PH_CC_B_HIGH: begin
				if (a && b) begin
					knob_phase = PH_IDLE;
					steps = steps - 1;
				end
			end
			default: knob_phase = PH_IDLE;
		endcase
		for (int i = 0; i < BUTTON_N; i++)
			on[i] = (stable[LVL_BUTTON0 + i] == closed_mask[i]);
		r.trigger_on       = on[0];
		r.preset_a_on      = on[1];
		r.preset_b_on      = on[2];
		r.preset_c_on      = on[3];
		r.trigger_toggled  = on[0] ^ flags_reported[0];
		r.preset_a_toggled = on[1] ^ flags_reported[1];
		r.preset_b_toggled = on[2] ^ flags_reported[2];
		r.preset_c_toggled = on[3] ^ flags_reported[3];
		r.position_delta   = steps - steps_at_report;
		r.position         = steps;
		if (s.kind == KIND_REPORT) begin
			flags_reported  = on;
			steps_at_report = steps;
		end
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_report(input report_t want, input report_t got);
		check_field("trigger_on", want.trigger_on, got.trigger_on);
		check_field("preset_a_on", want.preset_a_on, got.preset_a_on);
		check_field("preset_b_on", want.preset_b_on, got.preset_b_on);
		check_field("preset_c_on", want.preset_c_on, got.preset_c_on);
		check_field("trigger_toggled", want.trigger_toggled, got.trigger_toggled);
		check_field("preset_a_toggled", want.preset_a_toggled, got.preset_a_toggled);
		check_field("preset_b_toggled", want.preset_b_toggled, got.preset_b_toggled);
		check_field("preset_c_toggled", want.preset_c_toggled, got.preset_c_toggled);
		check_field("position_delta", $signed(want.position_delta), $signed(got.position_delta));
		check_field("position", $signed(want.position), $signed(got.position));
	endtask

	// transfers are observed on the rising edge
	always @(posedge clk) begin
		report_t r;
		if (arst_n) begin
			if (sample_valid && sample_ready) begin
				apply_tick(sample, r);
				samples_taken++;
				if (sample.kind == KIND_REPORT)
					reports_due.push_back(cur_typed ? cur_want : r);
			end
			if (report_valid && report_ready) begin
				if (reports_due.size() == 0) begin
					$display("%0t: report transfer with none due, actual %p", $time, report);
					mismatches++;
				end else begin
					check_report(reports_due.pop_front(), report);
					reports_checked++;
				end
			end
		end
	end

	// watchdog on stalled handshakes
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (sample_valid && sample_ready) || (report_valid && report_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT)
				break;
		end
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// receiver pacing
	initial begin
		report_ready = 1'b0;
		forever begin
			@(negedge clk);
			report_ready = ($urandom_range(99) >= take_idle_pct);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_TRIGGER_HOLD:  hold_ticks[2] = val;
			REG_PRESET_A_HOLD: hold_ticks[3] = val;
			REG_PRESET_B_HOLD: hold_ticks[4] = val;
			REG_PRESET_C_HOLD: hold_ticks[5] = val;
			REG_ENCODER_HOLD: begin
				hold_ticks[0] = val;
				hold_ticks[1] = val;
			end
			REG_CLOSED_MASK:   closed_mask = val[MASK_W-1:0];
			default: ;
		endcase
	endtask

	// hold valid low until every due report is back and the block is quiet
	task automatic settle();
		sample_valid = 1'b0;
		while (reports_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// one sample transfer, with random idle cycles ahead of it
	task automatic send_tick(input sample_t s, input bit typed, input report_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample       = s;
		cur_typed    = typed;
		cur_want     = want;
		sample_valid = 1'b1;
		do @(posedge clk); while (!sample_ready);
		@(negedge clk);
	endtask

	// queue A/B levels for a clockwise or anticlockwise turn, maybe cut short, or random noise
	task automatic plan_knob();
		logic [1:0] cw [4];
		logic [1:0] ccw [4];
		int pick, n, dwell;
		cw  = '{2'b10, 2'b00, 2'b01, 2'b11};
		ccw = '{2'b01, 2'b00, 2'b10, 2'b11};
		pick = $urandom_range(99);
		if (pick < 90) begin
			n = (pick < 80) ? 4 : $urandom_range(1, 3);
			for (int k = 0; k < n; k++) begin
				dwell = hold_ticks[0] + 1 + $urandom_range(0, 2);
				repeat (dwell) knob_levels.push_back((pick % 2) ? cw[k] : ccw[k]);
			end
		end else begin
			repeat ($urandom_range(1, 4)) knob_levels.push_back(2'($urandom_range(3)));
		end
	endtask

	task automatic next_random(output sample_t s);
		logic [1:0] lv;
		if (knob_levels.size() == 0)
			plan_knob();
		lv = knob_levels.pop_front();
		for (int i = 0; i < BUTTON_N; i++)
			if ($urandom_range(99) < 6)
				button_raw[i] = ~button_raw[i];
		// levels are B then A inside lv
		s.kind         = ($urandom_range(99) < 35);
		s.raw_b        = lv[1];
		s.raw_a        = lv[0];
		s.raw_trigger  = button_raw[0];
		s.raw_preset_a = button_raw[1];
		s.raw_preset_b = button_raw[2];
		s.raw_preset_c = button_raw[3];
	endtask

	// stimulus
	initial begin
		sample_t s;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		sample_valid  = 1'b0;
		sample        = '0;
		cur_typed     = 1'b0;
		cur_want      = '0;
		send_idle_pct = 27;
		take_idle_pct = 47;
		mismatches    = 0;
		samples_taken = 0;
		reports_checked = 0;
		button_raw    = '0;
		for (int i = 0; i < PIN_N; i++) begin
			hold_ticks[i] = (i < LVL_BUTTON0) ? ENCODER_HOLD_RST : BUTTON_HOLD_RST;
			hold_cnt[i]   = '0;
		end
		closed_mask     = MASK_RST;
		knob_phase      = PH_IDLE;
		steps           = '0;
		steps_at_report = '0;
		flags_reported  = '0;
		stable          = '0;
		raw_prev        = '0;

		// columns: kind, A, B, trigger, preset A, preset B, preset C
		script = '{
			'{7'b1_00_0000, 1'b0, 1'b1, {8'hFF, 64'd0}},   // first report: all on, all toggled
			'{7'b1_00_0000, 1'b0, 1'b1, {8'hF0, 64'd0}},
			'{7'b0_10_0000, 1'b0, 1'b0, '0},                // clockwise turn, two ticks per level
			'{7'b0_10_0000, 1'b0, 1'b0, '0},
			'{7'b0_11_0000, 1'b0, 1'b0, '0},
			'{7'b1_11_0000, 1'b0, 1'b0, '0},
			'{7'b0_10_0000, 1'b0, 1'b0, '0},                // anticlockwise turn
			'{7'b0_10_0000, 1'b0, 1'b0, '0},
			'{7'b0_00_0000, 1'b0, 1'b0, '0},
			'{7'b0_00_0000, 1'b0, 1'b0, '0},
			'{7'b0_01_0000, 1'b0, 1'b0, '0},
			'{7'b0_01_0000, 1'b0, 1'b0, '0},
			'{7'b0_11_0000, 1'b0, 1'b0, '0},
			'{7'b1_11_0000, 1'b0, 1'b0, '0},
			'{7'b1_11_1111, 1'b0, 1'b0, '0},                // all pins high, buttons still bouncing
			'{7'b1_01_1010, 1'b1, 1'b0, '0},                // zero hold: levels taken at once
			'{7'b0_00_0101, 1'b0, 1'b0, '0},
			'{7'b1_10_0101, 1'b0, 1'b0, '0}
		};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// scripted part under reset configuration, until a zero-hold row sets all holds to zero
		foreach (script[i]) begin
			if (script[i].zero_holds) begin
				settle();
				write_reg(REG_TRIGGER_HOLD, '0);
				write_reg(REG_PRESET_A_HOLD, '0);
				write_reg(REG_PRESET_B_HOLD, '0);
				write_reg(REG_PRESET_C_HOLD, '0);
				write_reg(REG_ENCODER_HOLD, '0);
			end
			send_tick(script[i].pins, script[i].typed, script[i].want);
		end

		// random part: three pacing phases, each with its own settings
		for (int p = 0; p < 3; p++) begin
			settle();
			case (p)
				0: begin
					write_reg(REG_TRIGGER_HOLD, 16'd2);
					write_reg(REG_PRESET_A_HOLD, 16'd0);
					write_reg(REG_PRESET_B_HOLD, 16'd5);
					write_reg(REG_PRESET_C_HOLD, 16'hFFFF);
					write_reg(REG_ENCODER_HOLD, 16'd1);
					write_reg(REG_CLOSED_MASK, 16'h0006);
					write_reg(IDX_UNMAPPED_LO, 16'h0003);
				end
				1: begin
					send_idle_pct = 47;
					take_idle_pct = 27;
					write_reg(REG_TRIGGER_HOLD, 16'd0);
					write_reg(REG_PRESET_A_HOLD, 16'd7);
					write_reg(REG_PRESET_B_HOLD, 16'd1);
					write_reg(REG_PRESET_C_HOLD, 16'd3);
					write_reg(REG_ENCODER_HOLD, 16'd0);
					write_reg(REG_CLOSED_MASK, 16'h000F);
					write_reg(IDX_UNMAPPED_HI, 16'hFFFF);
				end
				default: begin
					send_idle_pct = 0;
					take_idle_pct = 0;
					write_reg(REG_TRIGGER_HOLD, 16'd4);
					write_reg(REG_PRESET_A_HOLD, 16'hFFFF);
					write_reg(REG_PRESET_B_HOLD, 16'd0);
					write_reg(REG_PRESET_C_HOLD, 16'd2);
					write_reg(REG_ENCODER_HOLD, 16'd3);
					// upper data bits must be dropped by the mask register
					write_reg(REG_CLOSED_MASK, 16'hFFF0);
				end
			endcase
			repeat (RANDOM_TICKS_PER_PHASE) begin
				next_random(s);
				send_tick(s, 1'b0, '0);
			end
		end

		// drain
		sample_valid = 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Run covered %0d sample transfers and %0d checked reports over", samples_taken,
			reports_checked);
		$display("scripted ticks plus random turns, noise and presses in three pacing phases.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
